// ===== hw/rtl/pct_pkg.sv =====
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types, character codes and helper functions of the percent codec.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] CHAR_PERCENT    = 8'h25;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_TILDE      = 8'h7E;
  localparam logic [7:0] CHAR_DOT        = 8'h2E;
  localparam logic [7:0] CHAR_DASH       = 8'h2D;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_NINE       = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F    = 8'h46;
  localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
  localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2
  } pct_pend_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } pct_job_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) ||
           ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) ||
           ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) begin
      v = c - CHAR_ZERO;
    end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
      v = c - CHAR_UPPER_A + 8'd10;
    end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) begin
      v = c - CHAR_LOWER_A + 8'd10;
    end else begin
      v = 8'd0;
    end
    return v[3:0];
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c);
    return is_digit(c) ||
           ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
           ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
           (c == CHAR_UNDERSCORE) || (c == CHAR_TILDE) ||
           (c == CHAR_DOT) || (c == CHAR_DASH);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CHAR_ZERO + {4'd0, nib};
    end else begin
      r = CHAR_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pct_if.sv =====
// ----------------------------------------------------------------------------
// pct_in_if / pct_out_if
// Valid/ready byte channels of the percent codec.
// ----------------------------------------------------------------------------
interface pct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface pct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hw/rtl/pct_front.sv =====
// ----------------------------------------------------------------------------
// pct_front
// Accepts input bytes, tracks the decode lookahead and turns each byte
// into a job of zero to three output bytes.
// ----------------------------------------------------------------------------
module pct_front import pct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     mode_we,
  input  logic     mode_wdata,
  pct_in_if.sink   in_ch,
  input  logic     full,
  output logic     push,
  output pct_job_t job
);

  logic       mode;
  pct_pend_t  pend;
  pct_pend_t  pend_next;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;
  logic       accept;
  logic [7:0] b;
  logic       lst;
  logic       b_hex;
  logic       b_opens;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;
  assign b           = in_ch.data_byte;
  assign lst         = in_ch.is_last;
  assign b_hex       = is_hex(b);
  assign b_opens     = (b == CHAR_PERCENT) && !lst;

  always_comb begin
    pend_next       = pend;
    held_digit_next = held_digit;
    if (accept && (mode == MODE_DECODE)) begin
      case (pend)
        PEND_PCT: begin
          if (b_hex && !lst) begin
            pend_next       = PEND_DIGIT;
            held_digit_next = b;
          end else if (!b_hex && b_opens) begin
            pend_next = PEND_PCT;
          end else begin
            pend_next = PEND_NONE;
          end
        end
        PEND_DIGIT: begin
          pend_next = (!b_hex && b_opens) ? PEND_PCT : PEND_NONE;
        end
        default: begin
          pend_next = b_opens ? PEND_PCT : PEND_NONE;
        end
      endcase
    end
  end

  always_comb begin
    job      = '0;
    job.last = lst;
    job.b0   = CHAR_PERCENT;
    if (mode == MODE_ENCODE) begin
      if (is_unreserved(b)) begin
        job.cnt = 2'd1;
        job.b0  = b;
      end else begin
        job.cnt = 2'd3;
        job.b1  = hex_char(b[7:4]);
        job.b2  = hex_char(b[3:0]);
      end
    end else begin
      case (pend)
        PEND_PCT: begin
          if (b_hex && !lst) begin
            job.cnt = 2'd0;
          end else if (b_hex) begin
            job.cnt = 2'd2;
            job.b1  = b;
          end else if (b_opens) begin
            job.cnt = 2'd1;
          end else begin
            job.cnt = 2'd2;
            job.b1  = b;
          end
        end
        PEND_DIGIT: begin
          if (b_hex) begin
            job.cnt = 2'd1;
            job.b0  = {hex_val(held_digit), hex_val(b)};
          end else if (b_opens) begin
            job.cnt = 2'd2;
            job.b1  = held_digit;
          end else begin
            job.cnt = 2'd3;
            job.b1  = held_digit;
            job.b2  = b;
          end
        end
        default: begin
          if (b_opens) begin
            job.cnt = 2'd0;
          end else begin
            job.cnt = 2'd1;
            job.b0  = b;
          end
        end
      endcase
    end
  end

  assign push = accept && (job.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
      pend <= PEND_NONE;
    end else if (mode_we) begin
      mode <= mode_wdata;
      pend <= PEND_NONE;
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    held_digit <= held_digit_next;
  end

endmodule

// ===== hw/rtl/pct_fifo.sv =====
// ----------------------------------------------------------------------------
// pct_fifo
// Short job queue between the front and the back of the codec.
// ----------------------------------------------------------------------------
module pct_fifo import pct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  pct_job_t job_in,
  input  logic     pop,
  output pct_job_t job_out,
  output logic     full,
  output logic     nonempty
);

  pct_job_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_PTR_W:0]     count;

  assign full     = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign job_out  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

endmodule

// ===== hw/rtl/pct_back.sv =====
// ----------------------------------------------------------------------------
// pct_back
// Walks the head job byte by byte into the output register.
// ----------------------------------------------------------------------------
module pct_back import pct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  pct_job_t  job,
  input  logic      nonempty,
  output logic      pop,
  pct_out_if.source out_ch
);

  logic [1:0] idx;
  logic       final_byte;
  logic       load;
  logic       take;
  logic [7:0] sel;
  logic       ovalid;
  logic [7:0] obyte;
  logic       olast;

  assign final_byte = (idx == (job.cnt - 2'd1));
  assign load       = !ovalid || out_ch.ready;
  assign take       = nonempty && load;
  assign pop        = take && final_byte;

  always_comb begin
    case (idx)
      2'd0:    sel = job.b0;
      2'd1:    sel = job.b1;
      default: sel = job.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= 2'd0;
    end else begin
      if (load) begin
        ovalid <= nonempty;
      end
      if (take) begin
        idx <= final_byte ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      obyte <= sel;
      olast <= job.last && final_byte;
    end
  end

  assign out_ch.valid    = ovalid;
  assign out_ch.out_byte = obyte;
  assign out_ch.out_last = olast;

endmodule

// ===== hw/rtl/percent_encode_decode_top.sv =====
// ----------------------------------------------------------------------------
// percent_encode_decode_top
// The first output byte of an input transaction is registered in the job queue and then in the output register.
// Throughput: one output byte per cycle while the sink is ready, set by the
//   back-end byte walker; once the two-entry job queue fills, the input waits
//   until the head job's last output byte, the third of an escaped byte, is taken.
// Reset (synchronous, active high): mode returns to encode, lookahead and
//   job queue empty, no output valid.
// ----------------------------------------------------------------------------
module percent_encode_decode_top import pct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      mode_we,
  input  logic      mode_wdata,
  pct_in_if.sink    in_ch,
  pct_out_if.source out_ch
);

  pct_job_t job_in;
  pct_job_t job_out;
  logic     push;
  logic     pop;
  logic     full;
  logic     nonempty;

  pct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .in_ch      (in_ch),
    .full       (full),
    .push       (push),
    .job        (job_in)
  );

  pct_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .job_in   (job_in),
    .pop      (pop),
    .job_out  (job_out),
    .full     (full),
    .nonempty (nonempty)
  );

  pct_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (job_out),
    .nonempty (nonempty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== hw/rtl/pct_checker.sv =====
// ----------------------------------------------------------------------------
// pct_checker
// Port-level checks of the percent codec, bound to the top level.
// ----------------------------------------------------------------------------
module pct_checker import pct_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       mode_we,
  input logic       mode_wdata,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  logic mode_q;
  logic seen;
  logic enc_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q <= MODE_ENCODE;
      seen   <= 1'b0;
    end else begin
      if (mode_we) begin
        mode_q <= mode_wdata;
      end
      if (in_valid && in_ready) begin
        seen <= 1'b1;
      end
    end
  end

  assign enc_ok = is_unreserved(out_byte) || (out_byte == CHAR_PERCENT);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output transaction changed");

  a_enc_alphabet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode_q == MODE_ENCODE) |-> enc_ok)
    else $error("encoded output outside the unreserved set");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seen)
    else $error("output transaction without any input transaction");

endmodule

bind percent_encode_decode_top pct_checker u_pct_checker (
  .clk        (clk),
  .rst        (rst),
  .mode_we    (mode_we),
  .mode_wdata (mode_wdata),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .out_last   (out_ch.out_last)
);

// ===== verif/tb_percent_encode_decode_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_percent_encode_decode_top
// Streams strings through the percent codec in both modes, predicts every
// converted byte and its last flag in the bench, and checks the output
// channel in order under varied source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_percent_encode_decode_top;
  import pct_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_REPORTS    = 10;
  localparam int ENC_ITEMS      = 40;
  localparam int DEC_ITEMS      = 42;
  localparam int SRC_IDLE[4]    = '{0, 61, 0, 25};
  localparam int SNK_STALL[4]   = '{0, 0, 61, 25};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } str_byte_t;

  logic clk        = 1'b0;
  logic rst        = 1'b1;
  logic mode_we    = 1'b0;
  logic mode_wdata = 1'b0;

  pct_in_if  in_ch();
  pct_out_if out_ch();

  percent_encode_decode_top dut (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #4 clk = ~clk;

  str_byte_t  send_q[$];
  str_byte_t  expected_q[$];
  int         inflight;
  logic       codec_mode;
  pct_pend_t  lookahead;
  logic [7:0] held_hex;
  int         src_idle_pct;
  int         sink_stall_pct;
  int         mismatches;
  int         stall_cycles;

  function automatic logic is_hex_ascii(input logic [7:0] c);
    return (c >= CHAR_ZERO && c <= CHAR_NINE) ||
           (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) ||
           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F);
  endfunction

  function automatic logic [3:0] ascii_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      v = c - CHAR_UPPER_A + 8'd10;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      v = c - CHAR_LOWER_A + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
    logic [7:0] w;
    w = {4'd0, n};
    return (n < 4'd10) ? CHAR_ZERO + w : CHAR_UPPER_A + w - 8'd10;
  endfunction

  function automatic logic is_url_safe(input logic [7:0] c);
    return (c >= CHAR_ZERO && c <= CHAR_NINE) ||
           (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
           c == CHAR_UNDERSCORE || c == CHAR_TILDE ||
           c == CHAR_DOT || c == CHAR_DASH;
  endfunction

  function automatic void expect_byte(input logic [7:0] b, input logic last);
    expected_q.push_back('{data: b, last: last});
  endfunction

  function automatic void decode_unheld(input logic [7:0] b, input logic last);
    if (b == CHAR_PERCENT && !last) begin
      lookahead = PEND_PCT;
    end else begin
      expect_byte(b, last);
    end
  endfunction

  function automatic void predict_codec(input logic [7:0] b, input logic last);
    if (codec_mode == MODE_ENCODE) begin
      if (is_url_safe(b)) begin
        expect_byte(b, last);
      end else begin
        expect_byte(CHAR_PERCENT, 1'b0);
        expect_byte(nibble_ascii(b[7:4]), 1'b0);
        expect_byte(nibble_ascii(b[3:0]), last);
      end
    end else begin
      case (lookahead)
        PEND_PCT: begin
          lookahead = PEND_NONE;
          if (is_hex_ascii(b) && !last) begin
            held_hex  = b;
            lookahead = PEND_DIGIT;
          end else begin
            expect_byte(CHAR_PERCENT, 1'b0);
            decode_unheld(b, last);
          end
        end
        PEND_DIGIT: begin
          lookahead = PEND_NONE;
          if (is_hex_ascii(b)) begin
            expect_byte({ascii_nibble(held_hex), ascii_nibble(b)}, last);
          end else begin
            expect_byte(CHAR_PERCENT, 1'b0);
            expect_byte(held_hex, 1'b0);
            decode_unheld(b, last);
          end
        end
        default: begin
          lookahead = PEND_NONE;
          decode_unheld(b, last);
        end
      endcase
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic last);
    send_q.push_back('{data: b, last: last});
    inflight++;
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i], i == s.len() - 1);
    end
  endfunction

  function automatic void queue_bytes(input logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) begin
      queue_byte(s[i], i == s.size() - 1);
    end
  endfunction

  function automatic logic [7:0] rand_safe_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (!is_url_safe(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_hex_ascii();
    logic [3:0] n;
    logic [7:0] c;
    n = 4'($urandom_range(15));
    c = nibble_ascii(n);
    if (n >= 4'd10 && $urandom_range(1) == 1) begin
      c = c + 8'h20;
    end
    return c;
  endfunction

  function automatic int queue_encode_string();
    logic [7:0] s[$];
    int         len;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      s.push_back($urandom_range(1) ? rand_safe_char() : 8'($urandom_range(255)));
    end
    queue_bytes(s);
    return len;
  endfunction

  function automatic int queue_decode_string();
    logic [7:0] s[$];
    int         tokens;
    int         pick;
    tokens = $urandom_range(1, 5);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        s.push_back(rand_safe_char());
      end else if (pick < 78) begin
        s.push_back(CHAR_PERCENT);
        s.push_back(rand_hex_ascii());
        s.push_back(rand_hex_ascii());
      end else if (pick < 88) begin
        s.push_back(8'($urandom_range(255)));
      end else if (pick < 94) begin
        s.push_back(CHAR_PERCENT);
      end else begin
        s.push_back(CHAR_PERCENT);
        s.push_back(rand_hex_ascii());
      end
    end
    queue_bytes(s);
    return s.size();
  endfunction

  task automatic write_mode(input logic value);
    @(posedge clk);
    mode_we    <= 1'b1;
    mode_wdata <= value;
    codec_mode = value;
    lookahead  = PEND_NONE;
    held_hex   = 8'd0;
    @(posedge clk);
    mode_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (inflight != 0 || expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Source driver: advance to the next byte once the current one is taken.
  always @(posedge clk) begin
    str_byte_t nxt;
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= 8'd0;
      in_ch.is_last   <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = send_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= nxt.data;
        in_ch.is_last   <= nxt.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      predict_codec(in_ch.data_byte, in_ch.is_last);
      inflight--;
    end
  end

  always @(posedge clk) begin
    str_byte_t exp_b;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] unexpected transaction: byte %02h last %0b", $realtime,
                   out_ch.out_byte, out_ch.out_last);
        end
      end else begin
        exp_b = expected_q.pop_front();
        if (out_ch.out_byte !== exp_b.data || out_ch.out_last !== exp_b.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     $realtime, exp_b.data, exp_b.last, out_ch.out_byte, out_ch.out_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int count;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.is_last   = 1'b0;
    out_ch.ready    = 1'b0;
    inflight        = 0;
    mismatches      = 0;
    stall_cycles    = 0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    codec_mode      = MODE_ENCODE;
    lookahead       = PEND_NONE;
    held_hex        = 8'd0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_mode(MODE_ENCODE);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_text("Az_~.-/%");
    wait_drained();

    write_mode(MODE_DECODE);
    queue_text("%6a%");
    queue_text("%4");
    queue_text("%4%41");
    queue_text("%z");
    // hold a bare percent, then drop it with a mode write
    queue_byte(CHAR_PERCENT, 1'b0);
    wait_drained();
    write_mode(MODE_DECODE);
    queue_text("7");
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = SRC_IDLE[p];
      sink_stall_pct = SNK_STALL[p];
      write_mode(MODE_ENCODE);
      count = 0;
      while (count < ENC_ITEMS) begin
        count += queue_encode_string();
      end
      wait_drained();
      write_mode(MODE_DECODE);
      count = 0;
      while (count < DEC_ITEMS) begin
        count += queue_decode_string();
      end
      wait_drained();
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
